[rtl/core/kda_pkg.sv]
package kda_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_SHOT_ENABLE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DELAY_TICKS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD     = 3'd5;

  // Field widths
  localparam int unsigned DEB_W  = 8;
  localparam int unsigned HOLD_W = 10;
  localparam int unsigned REP_W  = 8;

  // Reset values
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd20;
  localparam logic [HOLD_W-1:0] HOLD_RESET     = 10'd400;
  localparam logic [REP_W-1:0]  REPEAT_RESET   = 8'd100;

  typedef struct packed {
    logic              active_high;
    logic [DEB_W-1:0]  debounce_ticks;
    logic              one_shot_enable;
    logic              long_press_enable;
    logic [HOLD_W-1:0] hold_delay_ticks;
    logic [REP_W-1:0]  repeat_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic key_event;
    logic debounced_pressed;
  } result_t;

endpackage

[rtl/core/kda_engine.sv]
// Debounce counters, armed flag, event latch and auto-repeat counters.
// State advances on step; result is the post-update value for the top to register.
module kda_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              pin_level,
  input  kda_pkg::cfg_t     cfg,
  output kda_pkg::result_t  result
);

  logic [kda_pkg::DEB_W-1:0]  press_count, press_count_next;
  logic [kda_pkg::DEB_W-1:0]  release_count, release_count_next;
  logic                       armed_for_press, armed_for_press_next;
  logic                       event_latch, event_latch_next;
  logic [kda_pkg::HOLD_W-1:0] hold_count, hold_count_next;
  logic [kda_pkg::REP_W-1:0]  repeat_count, repeat_count_next;

  logic                       pressed;
  logic                       press_stable;
  logic                       release_stable;
  logic [kda_pkg::DEB_W:0]    press_inc;
  logic [kda_pkg::DEB_W:0]    release_inc;
  logic [kda_pkg::HOLD_W:0]   hold_inc;
  logic [kda_pkg::REP_W:0]    repeat_inc;

  always_comb begin
    pressed     = cfg.active_high ? pin_level : ~pin_level;
    press_inc   = {1'b0, press_count} + 1'b1;
    release_inc = {1'b0, release_count} + 1'b1;
    hold_inc    = {1'b0, hold_count} + 1'b1;
    repeat_inc  = {1'b0, repeat_count} + 1'b1;

    press_count_next     = press_count;
    release_count_next   = release_count;
    armed_for_press_next = armed_for_press;
    event_latch_next     = event_latch;
    hold_count_next      = hold_count;
    repeat_count_next    = repeat_count;

    if (pressed) begin
      release_count_next = '0;
      press_count_next = (press_inc >= {1'b0, cfg.debounce_ticks}) ?
                         cfg.debounce_ticks : press_inc[kda_pkg::DEB_W-1:0];
    end else begin
      press_count_next = '0;
      release_count_next = (release_inc >= {1'b0, cfg.debounce_ticks}) ?
                           cfg.debounce_ticks : release_inc[kda_pkg::DEB_W-1:0];
    end

    press_stable   = press_count_next >= cfg.debounce_ticks;
    release_stable = release_count_next >= cfg.debounce_ticks;

    if (press_stable && armed_for_press) begin
      armed_for_press_next = 1'b0;
      event_latch_next     = 1'b1;
    end else if (release_stable && !armed_for_press) begin
      armed_for_press_next = 1'b1;
      event_latch_next     = 1'b0;
    end else if (cfg.one_shot_enable) begin
      event_latch_next = 1'b0;
    end

    if (cfg.long_press_enable) begin
      if (pressed && press_stable) begin
        if (hold_count == '0) begin
          event_latch_next = 1'b1;
        end else if (hold_count == cfg.hold_delay_ticks) begin
          if (repeat_inc >= {1'b0, cfg.repeat_period_ticks}) begin
            repeat_count_next = '0;
            event_latch_next  = 1'b1;
          end else begin
            repeat_count_next = repeat_inc[kda_pkg::REP_W-1:0];
            event_latch_next  = 1'b0;
          end
        end else begin
          event_latch_next = 1'b0;
        end
        hold_count_next = (hold_inc >= {1'b0, cfg.hold_delay_ticks}) ?
                          cfg.hold_delay_ticks : hold_inc[kda_pkg::HOLD_W-1:0];
      end else if (!pressed && release_stable) begin
        hold_count_next   = '0;
        repeat_count_next = '0;
      end
    end

    result.key_event         = event_latch_next;
    result.debounced_pressed = ~armed_for_press_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count     <= '0;
      release_count   <= '0;
      armed_for_press <= 1'b0;
      event_latch     <= 1'b0;
      hold_count      <= '0;
      repeat_count    <= '0;
    end else if (step) begin
      press_count     <= press_count_next;
      release_count   <= release_count_next;
      armed_for_press <= armed_for_press_next;
      event_latch     <= event_latch_next;
      hold_count      <= hold_count_next;
      repeat_count    <= repeat_count_next;
    end
  end

  // a run of one polarity always clears the other count
  assert property (@(posedge clk) disable iff (rst)
    !((press_count != '0) && (release_count != '0)))
    else $error("press and release counts both nonzero");

endmodule

[rtl/core/key_debounce_autorepeat_unit.sv]
// Key debouncer with optional auto-repeat. One pin sample per input beat
// (s_tdata[0]) gives exactly one result beat: key_event in m_tdata[0] and
// debounced_pressed in m_tdata[1]. The block takes one beat per clock cycle
// for as long as the output side keeps up; a sample waits in the input
// register until the output slot is free, and its result is then captured
// in the output register. The key state (debounce counters, armed flag,
// event latch, hold and repeat counters) updates once per sample, which is
// what sets that rate. Settings are written through the cfg
// port (indexes 0..5: active_high, debounce_ticks, one_shot_enable,
// long_press_enable, hold_delay_ticks, repeat_period_ticks); write them only
// while no beat is in flight. Reset values: active low, 20 ticks debounce,
// one-shot on, long press off, 400 ticks hold delay, 100 ticks repeat period.
module key_debounce_autorepeat_unit (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] pin_level
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [0] key_event, [1] debounced_pressed
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kda_pkg::CFG_DATA_W-1:0]  cfg_data
);

  kda_pkg::cfg_t    cfg;
  kda_pkg::result_t result;

  // input register
  logic in_valid;
  logic in_pin;
  // output register
  logic out_valid;
  logic out_event;
  logic out_pressed;

  logic advance;   // input-register beat moves into the output register
  logic step;

  assign cfg_ready = 1'b1;

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high         <= 1'b0;
      cfg.debounce_ticks      <= kda_pkg::DEBOUNCE_RESET;
      cfg.one_shot_enable     <= 1'b1;
      cfg.long_press_enable   <= 1'b0;
      cfg.hold_delay_ticks    <= kda_pkg::HOLD_RESET;
      cfg.repeat_period_ticks <= kda_pkg::REPEAT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kda_pkg::REG_ACTIVE_HIGH:       cfg.active_high       <= cfg_data[0];
        kda_pkg::REG_DEBOUNCE_TICKS:    cfg.debounce_ticks    <= cfg_data[kda_pkg::DEB_W-1:0];
        kda_pkg::REG_ONE_SHOT_ENABLE:   cfg.one_shot_enable   <= cfg_data[0];
        kda_pkg::REG_LONG_PRESS_ENABLE: cfg.long_press_enable <= cfg_data[0];
        kda_pkg::REG_HOLD_DELAY_TICKS:  cfg.hold_delay_ticks  <= cfg_data[kda_pkg::HOLD_W-1:0];
        kda_pkg::REG_REPEAT_PERIOD:
          cfg.repeat_period_ticks <= cfg_data[kda_pkg::REP_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // output slot is free or being emptied this cycle
  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pin <= s_tdata[0];
    end
  end

  kda_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (in_pin),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event   <= result.key_event;
      out_pressed <= result.debounced_pressed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_pressed, out_event};

  // a result beat only leaves when taken
  assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(m_tready))
    else $error("result beat dropped");

  // a held input beat keeps its sample
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_pin)))
    else $error("stalled input beat lost");

  // a full output slot that is not taken keeps its result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_event) && $stable(out_pressed)))
    else $error("stalled result beat changed");

endmodule
